// ===== rtl/bcf_pkg.sv =====
// Shared constants, types and helpers for the Bezier curve flattener.
`timescale 1ns / 1ps

package bcf_pkg;

  localparam int CoordBits  = 16;
  localparam int MaxSamples = 64;
  localparam int CountW     = 7;
  localparam int FracW      = 16;
  localparam int TW         = FracW + 1;
  localparam int DivW       = $clog2(2 * (MaxSamples - 1) + 1);
  localparam int DivCntW    = $clog2(TW + 1);
  localparam int StepW      = 4;

  localparam logic [TW-1:0] TOne = TW'(1) << FracW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // One interpolation each; the order is also the cubic issue order.
  typedef enum logic [StepW-1:0] {
    OP_AX, OP_AY, OP_BX, OP_BY, OP_CX, OP_CY,
    OP_DX, OP_DY, OP_EX, OP_EY, OP_RX, OP_RY
  } op_t;

  localparam logic [StepW-1:0] QuadLastStep  = StepW'(5);
  localparam logic [StepW-1:0] CubicLastStep = StepW'(11);

  // A quadratic curve needs only the first two levels, so its fifth and sixth
  // issue slots produce the final point directly.
  function automatic op_t op_for_step(input logic [StepW-1:0] step, input logic cubic);
    op_t op;
    op = op_t'(step);
    if (!cubic && op == OP_CX) op = OP_RX;
    if (!cubic && op == OP_CY) op = OP_RY;
    return op;
  endfunction

endpackage

// ===== rtl/bezier_curve_flattener_unit.sv =====
// Top level of the Bezier curve flattener: sequencer, t stepper and shared lerp unit.
`timescale 1ns / 1ps

// Channel  Handshake            Beat contents
// -------  -------------------  -----------------------------------------------
// in       in_valid / in_ready  degree_sel, p0..p3 (x, y), sample_count
// out      out_valid/out_ready  out_x, out_y, last_point
//
// A curve with n >= 2 points first runs a restoring divider that
// splits 2^17 / (2*(n-1)) into a quotient and remainder for the t stepper.
// Each point then issues 6 (quadratic) or 12 (cubic) interpolations on the one
// shared multiplier, then passes through a drain state and the output state.
// in_ready is high only while no curve is being worked on. A stalled output
// simply holds the block in place. Reset returns the sequencer to idle.

module bezier_curve_flattener_unit #(
  parameter int COORD_BITS = bcf_pkg::CoordBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         degree_sel,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  input  logic [bcf_pkg::CountW-1:0]   sample_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         last_point
);

  import bcf_pkg::*;

  localparam int CW = COORD_BITS;

  state_t state, state_next;

  // Latched curve.
  logic [CW-1:0]     px [4];
  logic [CW-1:0]     py [4];
  logic              held_degree;
  logic [CountW-1:0] total_points;
  logic [CountW-1:0] point_index;

  // Divider and t stepper. t_i = floor((i*2^17 + span) / divisor), divisor = 2*span.
  logic [DivW-1:0]    divisor;
  logic [DivCntW-1:0] div_cnt;
  logic [DivW-1:0]    div_rem;
  logic [TW-1:0]      t_quot;
  logic [TW-1:0]      t_cur;
  logic [DivW-1:0]    t_rem;

  // De Casteljau intermediates.
  logic [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy, ex, ey;

  // Shared lerp unit.
  logic [StepW-1:0]       step;
  op_t                    op;
  logic [CW-1:0]          lerp_a, lerp_b;
  logic signed [CW:0]     diff;
  logic signed [TW:0]     t_signed;
  logic signed [CW+TW+1:0] prod_full;
  logic                   wb_valid;
  op_t                    wb_op;
  logic [CW-1:0]          wb_base;
  logic signed [CW+TW+1:0] wb_prod;
  logic [CW-1:0]          wb_res;

  logic [CountW-1:0] n_in;
  logic              in_fire, out_fire, is_last, issue, div_run;
  logic [StepW-1:0]  last_step;
  logic [DivW:0]     div_trial;
  logic              div_bit, div_ge;
  logic [DivW:0]     t_sum;
  logic              t_carry;

  // Counts above the limit are clipped to the limit.
  assign n_in = (sample_count > CountW'(MaxSamples)) ? CountW'(MaxSamples) : sample_count;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign is_last   = (point_index + CountW'(1)) == total_points;
  assign last_step = held_degree ? CubicLastStep : QuadLastStep;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && n_in != '0) begin
          state_next = (n_in == CountW'(1)) ? ST_CALC : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (step == last_step) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = is_last ? ST_IDLE : ST_CALC;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    issue     = 1'b0;
    div_run   = 1'b0;
    case (state)
      ST_IDLE:  in_ready  = 1'b1;
      ST_DIV:   div_run   = 1'b1;
      ST_CALC:  issue     = 1'b1;
      ST_DRAIN: ;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end

  assign last_point = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring divider: one quotient bit per cycle, dividend is 2^17.
  assign div_bit   = (div_cnt == DivCntW'(TW));
  assign div_trial = {div_rem, div_bit};
  assign div_ge    = div_trial >= {1'b0, divisor};

  // Remainder step of the t stepper.
  assign t_sum   = {1'b0, t_rem} + {1'b0, div_rem};
  assign t_carry = t_sum >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px[0] <= p0_x;  py[0] <= p0_y;
      px[1] <= p1_x;  py[1] <= p1_y;
      px[2] <= p2_x;  py[2] <= p2_y;
      px[3] <= p3_x;  py[3] <= p3_y;
      held_degree  <= degree_sel;
      total_points <= n_in;
      point_index  <= '0;
      divisor      <= DivW'({n_in - CountW'(1), 1'b0});
      t_rem        <= DivW'(n_in - CountW'(1));
      div_cnt      <= DivCntW'(TW);
      div_rem      <= '0;
      t_quot       <= '0;
      t_cur        <= '0;
      step         <= '0;
    end else if (div_run) begin
      div_cnt <= div_cnt - DivCntW'(1);
      div_rem <= div_ge ? DivW'(div_trial - {1'b0, divisor}) : div_trial[DivW-1:0];
      t_quot  <= {t_quot[TW-2:0], div_ge};
    end else if (issue) begin
      step <= step + StepW'(1);
    end else if (out_fire) begin
      step        <= '0;
      point_index <= point_index + CountW'(1);
      if (t_carry) begin
        t_rem <= DivW'(t_sum - {1'b0, divisor});
        t_cur <= t_cur + t_quot + TW'(1);
      end else begin
        t_rem <= t_sum[DivW-1:0];
        t_cur <= t_cur + t_quot;
      end
    end
  end

  // Operand selection for the shared lerp unit.
  always_comb begin
    op     = op_for_step(step, held_degree);
    lerp_a = '0;
    lerp_b = '0;
    case (op)
      OP_AX: begin lerp_a = px[0]; lerp_b = px[1]; end
      OP_AY: begin lerp_a = py[0]; lerp_b = py[1]; end
      OP_BX: begin lerp_a = px[1]; lerp_b = px[2]; end
      OP_BY: begin lerp_a = py[1]; lerp_b = py[2]; end
      OP_CX: begin lerp_a = px[2]; lerp_b = px[3]; end
      OP_CY: begin lerp_a = py[2]; lerp_b = py[3]; end
      OP_DX: begin lerp_a = ax;    lerp_b = bx;    end
      OP_DY: begin lerp_a = ay;    lerp_b = by;    end
      OP_EX: begin lerp_a = bx;    lerp_b = cx;    end
      OP_EY: begin lerp_a = by;    lerp_b = cy;    end
      OP_RX: begin
        lerp_a = held_degree ? dx : ax;
        lerp_b = held_degree ? ex : bx;
      end
      OP_RY: begin
        lerp_a = held_degree ? dy : ay;
        lerp_b = held_degree ? ey : by;
      end
      default: ;
    endcase
  end

  // The difference of two points fits one bit wider; the product is floored by
  // taking bits above the fraction, which is the arithmetic shift by 16.
  assign diff      = $signed({lerp_b[CW-1], lerp_b}) - $signed({lerp_a[CW-1], lerp_a});
  assign t_signed  = $signed({1'b0, t_cur});
  assign prod_full = diff * t_signed;
  assign wb_res    = wb_base + wb_prod[FracW +: CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    wb_op   <= op;
    wb_base <= lerp_a;
    wb_prod <= prod_full;
    if (wb_valid) begin
      case (wb_op)
        OP_AX:   ax    <= wb_res;
        OP_AY:   ay    <= wb_res;
        OP_BX:   bx    <= wb_res;
        OP_BY:   by    <= wb_res;
        OP_CX:   cx    <= wb_res;
        OP_CY:   cy    <= wb_res;
        OP_DX:   dx    <= wb_res;
        OP_DY:   dy    <= wb_res;
        OP_EX:   ex    <= wb_res;
        OP_EY:   ey    <= wb_res;
        OP_RX:   out_x <= wb_res;
        OP_RY:   out_y <= wb_res;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The block never takes a curve while a point is waiting at the output.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a point is pending");

  // Handing over the final point frees the block for the next curve.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_point) |=> in_ready)
    else $error("block not idle after the final point");

  // The stepped parameter never runs past one.
  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (t_cur <= TOne))
    else $error("t above one");

  // The final point of a curve with two or more points sits exactly at t = 1.
  a_t_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_point && total_points != CountW'(1)) |-> (t_cur == TOne))
    else $error("final point not at t = 1");
`endif

endmodule
